// ===== hdl/spqkr_pkg.sv =====
// Shared types and constants for the stable priority queue with keyed removal.
// Holds command, status and cell-control codes used by the cell and the top level.
// No dependencies.
`timescale 1ns / 1ps

package spqkr_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int KEY_BITS_DEF    = 32;
    localparam int PRIO_W          = 4;
    localparam int CMD_W           = 2;
    localparam int STATUS_W        = 2;

    typedef logic [PRIO_W-1:0] prio_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_CLEAR  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     cmp_en;
        prio_t    prio;
    } cell_ctrl_t;

endpackage

// ===== hdl/spqkr_cell.sv =====
// One slot of the sorted queue: holds a key, a priority and a valid bit.
// Shifts toward the rear on insert and toward the front on remove.
// Depends on spqkr_pkg.
`timescale 1ns / 1ps

module spqkr_cell #(
    parameter int KEY_BITS = spqkr_pkg::KEY_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  spqkr_pkg::cell_ctrl_t  ctrl,
    input  logic [KEY_BITS-1:0]    req_key,
    input  logic                   left_valid,
    input  logic [KEY_BITS-1:0]    left_key,
    input  spqkr_pkg::prio_t       left_prio,
    input  logic                   left_after,
    input  logic                   right_valid,
    input  logic [KEY_BITS-1:0]    right_key,
    input  spqkr_pkg::prio_t       right_prio,
    input  logic                   seen_in,
    output logic                   valid,
    output logic [KEY_BITS-1:0]    key,
    output spqkr_pkg::prio_t       prio,
    output logic                   after,
    output logic                   match,
    output logic                   seen_out
);

    logic                  valid_reg, valid_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    spqkr_pkg::prio_t      prio_reg, prio_next;
    logic                  match_reg, match_next;

    // New entry belongs at or before this slot
    assign after    = !valid_reg || (prio_reg > ctrl.prio);
    assign valid    = valid_reg;
    assign key      = key_reg;
    assign prio     = prio_reg;
    assign match    = match_reg;
    assign seen_out = seen_in || match_reg;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        prio_next  = prio_reg;
        match_next = ctrl.cmp_en ? (valid_reg && (key_reg == req_key)) : match_reg;
        unique case (ctrl.op)
            spqkr_pkg::CELL_HOLD:
            begin
            end
            spqkr_pkg::CELL_INSERT:
            begin
                if (after)
                begin
                    if (left_after)
                    begin
                        valid_next = left_valid;
                        key_next   = left_key;
                        prio_next  = left_prio;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        key_next   = req_key;
                        prio_next  = ctrl.prio;
                    end
                end
            end
            spqkr_pkg::CELL_REMOVE:
            begin
                // close the gap left by the first match
                if (seen_in || match_reg)
                begin
                    valid_next = right_valid;
                    key_next   = right_key;
                    prio_next  = right_prio;
                end
            end
            spqkr_pkg::CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        prio_reg <= prio_next;
    end

endmodule

// ===== hdl/stable_priority_queue_with_keyed_removal.sv =====
// Top level of the stable priority queue with keyed removal.
// Instantiates a row of spqkr_cell slots and the command sequencer.
// Depends on spqkr_pkg and spqkr_cell.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready) carries one command item: command, key and
//   priority_req. Commands are insert, remove by key, search by key and clear.
//   Output channel (out_valid/out_ready) carries one result item per command:
//   status, search hit and its priority, the entry count after the command,
//   and the front key/priority and rear key (zero when the queue is empty).
//   Entries sit in a row of slots sorted by ascending priority value; an insert
//   goes behind every entry of equal or lower value, so equal priorities leave
//   first-in first-out. Remove and search act on the frontmost matching key.
// Timing
//   Each item walks through a compare cycle (every slot checks its key), an
//   execute cycle (every slot shifts or holds in parallel) and a report cycle.
//   The report cycle writes the result into the output register; the sequencer
//   handles one item at a time and takes no new item before it is idle again.
//   in_ready is high only while the sequencer is idle; the output register lets
//   the next item be accepted while the previous result still waits.
// Reset and stall
//   Reset empties the queue and drops any pending result. If the receiver
//   stalls, the next result is held in the report cycle until the output
//   register frees up; nothing is lost or repeated.

module stable_priority_queue_with_keyed_removal #(
    parameter int QUEUE_DEPTH = spqkr_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_BITS    = spqkr_pkg::KEY_BITS_DEF,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [spqkr_pkg::CMD_W-1:0]     command,
    input  logic [KEY_BITS-1:0]             key,
    input  logic [spqkr_pkg::PRIO_W-1:0]    priority_req,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [spqkr_pkg::STATUS_W-1:0]  status,
    output logic                            hit,
    output logic [spqkr_pkg::PRIO_W-1:0]    hit_priority,
    output logic [CNT_W-1:0]                entry_total,
    output logic [KEY_BITS-1:0]             head_key,
    output logic [spqkr_pkg::PRIO_W-1:0]    head_priority,
    output logic [KEY_BITS-1:0]             tail_key
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC,
        S_REPORT
    } state_t;

    state_t                 state_reg;

    // Command being worked on
    spqkr_pkg::cmd_t        cmd_reg;
    logic [KEY_BITS-1:0]    key_reg;
    spqkr_pkg::prio_t       prio_reg;
    logic [CNT_W-1:0]       count_reg;

    // Result waiting for the report cycle
    spqkr_pkg::status_t     res_status_reg;
    logic                   res_hit_reg;
    spqkr_pkg::prio_t       res_hitp_reg;

    // Output register
    logic                   out_valid_reg;
    logic [spqkr_pkg::STATUS_W-1:0] out_status_reg;
    logic                   out_hit_reg;
    spqkr_pkg::prio_t       out_hitp_reg;
    logic [CNT_W-1:0]       out_count_reg;
    logic [KEY_BITS-1:0]    out_head_key_reg;
    spqkr_pkg::prio_t       out_head_prio_reg;
    logic [KEY_BITS-1:0]    out_tail_key_reg;

    // Slot row
    spqkr_pkg::cell_ctrl_t  cell_ctrl;
    logic                   cell_valid [QUEUE_DEPTH];
    logic [KEY_BITS-1:0]    cell_key   [QUEUE_DEPTH];
    spqkr_pkg::prio_t       cell_prio  [QUEUE_DEPTH];
    logic                   cell_after [QUEUE_DEPTH];
    logic                   cell_match [QUEUE_DEPTH];
    logic                   cell_seen  [QUEUE_DEPTH+1];

    logic                   found;
    logic                   full;
    logic                   empty;
    spqkr_pkg::status_t     status_next;
    logic                   hit_next;
    spqkr_pkg::prio_t       hitp_next;
    logic [CNT_W-1:0]       count_next;
    logic [KEY_BITS-1:0]    head_key_now;
    spqkr_pkg::prio_t       head_prio_now;
    logic [KEY_BITS-1:0]    tail_key_now;

    assign cell_seen[0] = 1'b0;
    assign found        = cell_seen[QUEUE_DEPTH];
    assign full         = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty        = (count_reg == '0);

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            logic                left_valid_w;
            logic [KEY_BITS-1:0] left_key_w;
            spqkr_pkg::prio_t    left_prio_w;
            logic                left_after_w;
            logic                right_valid_w;
            logic [KEY_BITS-1:0] right_key_w;
            spqkr_pkg::prio_t    right_prio_w;

            if (g == 0)
            begin : g_front
                assign left_valid_w = 1'b0;
                assign left_key_w   = '0;
                assign left_prio_w  = '0;
                assign left_after_w = 1'b0;
            end
            else
            begin : g_inner_l
                assign left_valid_w = cell_valid[g-1];
                assign left_key_w   = cell_key[g-1];
                assign left_prio_w  = cell_prio[g-1];
                assign left_after_w = cell_after[g-1];
            end

            if (g == QUEUE_DEPTH - 1)
            begin : g_rear
                assign right_valid_w = 1'b0;
                assign right_key_w   = '0;
                assign right_prio_w  = '0;
            end
            else
            begin : g_inner_r
                assign right_valid_w = cell_valid[g+1];
                assign right_key_w   = cell_key[g+1];
                assign right_prio_w  = cell_prio[g+1];
            end

            spqkr_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl),
                .req_key     (key_reg),
                .left_valid  (left_valid_w),
                .left_key    (left_key_w),
                .left_prio   (left_prio_w),
                .left_after  (left_after_w),
                .right_valid (right_valid_w),
                .right_key   (right_key_w),
                .right_prio  (right_prio_w),
                .seen_in     (cell_seen[g]),
                .valid       (cell_valid[g]),
                .key         (cell_key[g]),
                .prio        (cell_prio[g]),
                .after       (cell_after[g]),
                .match       (cell_match[g]),
                .seen_out    (cell_seen[g+1])
            );
        end
    endgenerate

    // Drive the slot row: compare in S_CMP, shift or clear in S_EXEC
    always_comb
    begin
        cell_ctrl.op     = spqkr_pkg::CELL_HOLD;
        cell_ctrl.cmp_en = (state_reg == S_CMP);
        cell_ctrl.prio   = prio_reg;
        if (state_reg == S_EXEC)
        begin
            unique case (cmd_reg)
                spqkr_pkg::CMD_INSERT:
                    if (!full)
                        cell_ctrl.op = spqkr_pkg::CELL_INSERT;
                spqkr_pkg::CMD_REMOVE:
                    if (found)
                        cell_ctrl.op = spqkr_pkg::CELL_REMOVE;
                spqkr_pkg::CMD_SEARCH:
                    cell_ctrl.op = spqkr_pkg::CELL_HOLD;
                spqkr_pkg::CMD_CLEAR:
                    cell_ctrl.op = spqkr_pkg::CELL_CLEAR;
            endcase
        end
    end

    // Status, hit and new count, from the match bits of the compare cycle
    always_comb
    begin
        status_next = spqkr_pkg::ST_OK;
        hit_next    = 1'b0;
        count_next  = count_reg;
        hitp_next   = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (cell_match[i] && !cell_seen[i])
                hitp_next = hitp_next | cell_prio[i];
        end
        unique case (cmd_reg)
            spqkr_pkg::CMD_INSERT:
            begin
                if (full)
                    status_next = spqkr_pkg::ST_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            spqkr_pkg::CMD_REMOVE:
            begin
                if (empty)
                    status_next = spqkr_pkg::ST_EMPTY;
                else if (!found)
                    status_next = spqkr_pkg::ST_MISSING;
                else
                    count_next = count_reg - CNT_W'(1);
            end
            spqkr_pkg::CMD_SEARCH:
            begin
                if (empty)
                    status_next = spqkr_pkg::ST_EMPTY;
                else if (!found)
                    status_next = spqkr_pkg::ST_MISSING;
                else
                    hit_next = 1'b1;
            end
            spqkr_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
        endcase
        if (!hit_next)
            hitp_next = '0;
    end

    // Front and rear of the row as it stands after the execute cycle
    always_comb
    begin
        head_key_now  = cell_valid[0] ? cell_key[0] : '0;
        head_prio_now = cell_valid[0] ? cell_prio[0] : '0;
        tail_key_now  = '0;
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            if (cell_valid[i] && !cell_valid[i+1])
                tail_key_now = tail_key_now | cell_key[i];
        end
        if (cell_valid[QUEUE_DEPTH-1])
            tail_key_now = tail_key_now | cell_key[QUEUE_DEPTH-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            count_reg         <= '0;
            cmd_reg           <= spqkr_pkg::CMD_CLEAR;
            key_reg           <= '0;
            prio_reg          <= '0;
            res_status_reg    <= spqkr_pkg::ST_OK;
            res_hit_reg       <= 1'b0;
            res_hitp_reg      <= '0;
            out_valid_reg     <= 1'b0;
            out_status_reg    <= '0;
            out_hit_reg       <= 1'b0;
            out_hitp_reg      <= '0;
            out_count_reg     <= '0;
            out_head_key_reg  <= '0;
            out_head_prio_reg <= '0;
            out_tail_key_reg  <= '0;
        end
        else
        begin
            // drop the taken result unless the report cycle refills the register
            if (out_valid_reg && out_ready && (state_reg != S_REPORT))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg   <= spqkr_pkg::cmd_t'(command);
                        key_reg   <= key;
                        prio_reg  <= priority_req;
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    res_status_reg <= status_next;
                    res_hit_reg    <= hit_next;
                    res_hitp_reg   <= hitp_next;
                    count_reg      <= count_next;
                    state_reg      <= S_REPORT;
                end
                S_REPORT:
                begin
                    // hold here until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_status_reg    <= res_status_reg;
                        out_hit_reg       <= res_hit_reg;
                        out_hitp_reg      <= res_hitp_reg;
                        out_count_reg     <= count_reg;
                        out_head_key_reg  <= head_key_now;
                        out_head_prio_reg <= head_prio_now;
                        out_tail_key_reg  <= tail_key_now;
                        state_reg         <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign hit           = out_hit_reg;
    assign hit_priority  = out_hitp_reg;
    assign entry_total   = out_count_reg;
    assign head_key      = out_head_key_reg;
    assign head_priority = out_head_prio_reg;
    assign tail_key      = out_tail_key_reg;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for stable_priority_queue_with_keyed_removal.
// Drives command items through a valid/ready channel and checks every result item
// against a sorted-queue predictor. Depends on spqkr_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH       = spqkr_pkg::QUEUE_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;   // cycles with no item moving on either side

    // One result item as the block should report it.
    typedef struct {
        spqkr_pkg::status_t status;
        logic               hit;
        spqkr_pkg::prio_t   hit_prio;
        logic [4:0]         total;
        logic [31:0]        head_key;
        spqkr_pkg::prio_t   head_prio;
        logic [31:0]        tail_key;
    } queue_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [1:0]       command = spqkr_pkg::CMD_CLEAR;
    logic [31:0]      key = '0;
    spqkr_pkg::prio_t priority_req = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [1:0]       status;
    logic             hit;
    spqkr_pkg::prio_t hit_priority;
    logic [4:0]       entry_total;
    logic [31:0]      head_key;
    spqkr_pkg::prio_t head_priority;
    logic [31:0]      tail_key;

    // Predictor state: front of the queue at slot 0.
    logic [31:0]      q_key [DEPTH];
    spqkr_pkg::prio_t q_prio [DEPTH];
    int               q_fill = 0;

    queue_result_t pending_results[$];
    logic [31:0]   key_pool [6];
    int            err_count = 0;

    // Traffic shaping knobs shared between the test tasks and the receiver.
    bit tx_steady = 1'b0;   // sender offers back to back
    bit rx_steady = 1'b0;   // receiver never stalls at random
    int rx_hold   = 0;      // cycles of forced back-pressure still to go
    int rx_stall  = 0;

    always #2 clk = ~clk;

    stable_priority_queue_with_keyed_removal dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .key           (key),
        .priority_req  (priority_req),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .hit           (hit),
        .hit_priority  (hit_priority),
        .entry_total   (entry_total),
        .head_key      (head_key),
        .head_priority (head_priority),
        .tail_key      (tail_key)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Apply one command to the predicted queue and return the result it yields.
    function automatic queue_result_t queue_model_step(spqkr_pkg::cmd_t op, logic [31:0] k,
                                                       spqkr_pkg::prio_t p);
        queue_result_t r;
        int            pos;
        int            i;
        r.status   = spqkr_pkg::ST_OK;
        r.hit      = 1'b0;
        r.hit_prio = '0;
        case (op)
            spqkr_pkg::CMD_INSERT:
            begin
                if (q_fill >= DEPTH)
                    r.status = spqkr_pkg::ST_FULL;
                else
                begin
                    // Land behind every entry of equal or smaller value.
                    pos = 0;
                    while (pos < q_fill && q_prio[pos] <= p)
                        pos++;
                    for (i = q_fill; i > pos; i--)
                    begin
                        q_key[i]  = q_key[i-1];
                        q_prio[i] = q_prio[i-1];
                    end
                    q_key[pos]  = k;
                    q_prio[pos] = p;
                    q_fill++;
                end
            end
            spqkr_pkg::CMD_REMOVE, spqkr_pkg::CMD_SEARCH:
            begin
                if (q_fill == 0)
                    r.status = spqkr_pkg::ST_EMPTY;
                else
                begin
                    pos = 0;
                    while (pos < q_fill && q_key[pos] != k)
                        pos++;
                    if (pos >= q_fill)
                        r.status = spqkr_pkg::ST_MISSING;
                    else if (op == spqkr_pkg::CMD_SEARCH)
                    begin
                        r.hit      = 1'b1;
                        r.hit_prio = q_prio[pos];
                    end
                    else
                    begin
                        for (i = pos; i + 1 < q_fill; i++)
                        begin
                            q_key[i]  = q_key[i+1];
                            q_prio[i] = q_prio[i+1];
                        end
                        q_fill--;
                    end
                end
            end
            default:
                q_fill = 0;
        endcase
        r.total = q_fill[4:0];
        if (q_fill > 0)
        begin
            r.head_key  = q_key[0];
            r.head_prio = q_prio[0];
            r.tail_key  = q_key[q_fill-1];
        end
        else
        begin
            r.head_key  = '0;
            r.head_prio = '0;
            r.tail_key  = '0;
        end
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // Send one command item; the expectation is recorded at the accepting edge.
    task automatic push_command(input spqkr_pkg::cmd_t op, input logic [31:0] k,
                                input spqkr_pkg::prio_t p);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid     <= 1'b0;
            command      <= 2'($urandom_range(0, 3));
            key          <= $urandom;
            priority_req <= 4'($urandom_range(0, 15));
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        command      <= op;
        key          <= k;
        priority_req <= p;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(queue_model_step(op, k, p));
    endtask

    // Drop valid and hold until every outstanding result item has come back.
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Keys for remove/search: usually one that sits in the queue right now.
    function automatic logic [31:0] pick_lookup_key();
        if (q_fill > 0 && $urandom_range(0, 99) < 70)
            return q_key[$urandom_range(0, q_fill - 1)];
        if ($urandom_range(0, 1))
            return key_pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    // Insert keys: half from a small pool so duplicates are common.
    function automatic logic [31:0] pick_insert_key();
        if ($urandom_range(0, 1))
            return key_pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    // Empty-queue corner cases: clear, search and remove with nothing stored.
    task automatic test_empty_queue();
        push_command(spqkr_pkg::CMD_CLEAR,  32'h0000_0000, 4'd0);
        push_command(spqkr_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 4'd15);
        push_command(spqkr_pkg::CMD_REMOVE, 32'h0000_0000, 4'd0);
    endtask

    // Ordering, FIFO among equal priorities, duplicate keys, hits and misses.
    task automatic test_ordering();
        push_command(spqkr_pkg::CMD_INSERT, 32'hFFFF_FFFF, 4'd15);
        push_command(spqkr_pkg::CMD_INSERT, 32'h0000_0000, 4'd0);
        push_command(spqkr_pkg::CMD_INSERT, 32'h0000_00A0, 4'd7);
        push_command(spqkr_pkg::CMD_INSERT, 32'h0000_00B0, 4'd7);
        // duplicate key nearer the front
        push_command(spqkr_pkg::CMD_INSERT, 32'h0000_00A0, 4'd3);
        push_command(spqkr_pkg::CMD_SEARCH, 32'h0000_00A0, 4'd0);
        push_command(spqkr_pkg::CMD_SEARCH, 32'h1234_5678, 4'd0);
        push_command(spqkr_pkg::CMD_REMOVE, 32'h8765_4321, 4'd0);
        // takes the frontmost copy
        push_command(spqkr_pkg::CMD_REMOVE, 32'h0000_00A0, 4'd0);
        push_command(spqkr_pkg::CMD_SEARCH, 32'h0000_00A0, 4'd0);
        // drop the rear entry
        push_command(spqkr_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 4'd0);
        push_command(spqkr_pkg::CMD_CLEAR,  32'h5555_5555, 4'd9);
    endtask

    // Fill to capacity, then try to overflow it.
    task automatic test_full_queue();
        push_command(spqkr_pkg::CMD_CLEAR, $urandom, 4'($urandom_range(0, 15)));
        while (q_fill < DEPTH)
            push_command(spqkr_pkg::CMD_INSERT, pick_insert_key(),
                         4'($urandom_range(0, 15)));
        push_command(spqkr_pkg::CMD_INSERT, 32'hFFFF_FFFF, 4'd0);
        push_command(spqkr_pkg::CMD_INSERT, $urandom, 4'd15);
        push_command(spqkr_pkg::CMD_SEARCH, pick_lookup_key(), 4'd0);
        push_command(spqkr_pkg::CMD_REMOVE, pick_lookup_key(), 4'd0);
    endtask

    // Starve the output for a long stretch while items keep coming, so the
    // block backs up and drops in_ready.
    task automatic test_output_backpressure();
        tx_steady = 1'b1;
        rx_hold   = 300;
        repeat (10)
            push_command(spqkr_pkg::CMD_INSERT, pick_insert_key(),
                         4'($urandom_range(0, 15)));
        tx_steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        int              seg;
        int              n;
        int              r;
        int              ins_pct;
        spqkr_pkg::cmd_t op;
        for (seg = 0; seg < 8; seg++)
        begin
            // Alternate between filling and draining phases.
            ins_pct   = (seg % 2 == 0) ? 70 : 25;
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (n = 0; n < 42; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    op = spqkr_pkg::CMD_CLEAR;
                else if (r < 3 + ins_pct)
                    op = spqkr_pkg::CMD_INSERT;
                else if (r < 3 + ins_pct + (97 - ins_pct) / 2)
                    op = spqkr_pkg::CMD_REMOVE;
                else
                    op = spqkr_pkg::CMD_SEARCH;
                push_command(op,
                             (op == spqkr_pkg::CMD_INSERT) ? pick_insert_key()
                                                           : pick_lookup_key(),
                             4'($urandom_range(0, 15)));
            end
            // Pause the sender now and then until the output has caught up.
            if (seg == 2 || seg == 5)
                wait_for_results();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Receiver: random stalls, forced hold-off when asked.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold--;
        end
        else if (rx_stall > 0)
        begin
            out_ready <= 1'b0;
            rx_stall--;
        end
        else if (!rx_steady && $urandom_range(0, 99) < 25)
        begin
            out_ready <= 1'b0;
            rx_stall = pick_gap();
        end
        else
            out_ready <= 1'b1;
    end

    // Compare each accepted result item with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        queue_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_error("result item with no command outstanding");
            else
            begin
                want = pending_results.pop_front();
                check_field("status",        32'(status),        32'(want.status));
                check_field("hit",           32'(hit),           32'(want.hit));
                check_field("hit_priority",  32'(hit_priority),  32'(want.hit_prio));
                check_field("entry_total",   32'(entry_total),   32'(want.total));
                check_field("head_key",      head_key,           want.head_key);
                check_field("head_priority", 32'(head_priority), 32'(want.head_prio));
                check_field("tail_key",      tail_key,           want.tail_key);
            end
        end
    end

    // Abort when nothing moves on either channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'hA5A5_A5A5;
        key_pool[3] = $urandom;
        key_pool[4] = $urandom;
        key_pool[5] = $urandom;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_ordering();
        test_full_queue();
        wait_for_results();
        test_output_backpressure();
        test_random_traffic();
        test_full_queue();

        // Let the tail of the traffic drain, then keep watching for stray result items.
        wait_for_results();
        repeat (12) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
